>>> hdl/segment_intersection_top_macros.svh
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_TOP_MACROS_SVH
`define SEGMENT_INTERSECTION_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SEGI_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SEGI_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/segi_pkg.sv
// shared constants for the segment intersection block
package segi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int T_FRAC_BITS = 16;

	localparam logic [1:0] KIND_CROSS  = 2'd0;
	localparam logic [1:0] KIND_INSIDE = 2'd1;
	localparam logic [1:0] KIND_ORIGIN = 2'd2;

endpackage

>>> hdl/segi_in_if.sv
// input channel: one segment pair per beat
interface segi_in_if #(
	parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] seg_a_start_x;
	logic signed [COORD_WIDTH-1:0] seg_a_start_y;
	logic signed [COORD_WIDTH-1:0] seg_a_end_x;
	logic signed [COORD_WIDTH-1:0] seg_a_end_y;
	logic signed [COORD_WIDTH-1:0] seg_b_start_x;
	logic signed [COORD_WIDTH-1:0] seg_b_start_y;
	logic signed [COORD_WIDTH-1:0] seg_b_end_x;
	logic signed [COORD_WIDTH-1:0] seg_b_end_y;

	modport source (
		output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
		output seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
		input  ready
	);
	modport sink (
		input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
		input  seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
		output ready
	);
endinterface

>>> hdl/segi_out_if.sv
// output channel: one intersection result per beat
interface segi_out_if #(
	parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH,
	parameter int T_FRAC_BITS = segi_pkg::T_FRAC_BITS
);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [1:0]                    hit_kind;
	logic signed [COORD_WIDTH-1:0] hit_x;
	logic signed [COORD_WIDTH-1:0] hit_y;
	logic [T_FRAC_BITS:0]          hit_t;

	modport source (output valid, hit, hit_kind, hit_x, hit_y, hit_t, input ready);
	modport sink (input valid, hit, hit_kind, hit_x, hit_y, hit_t, output ready);
endinterface

>>> hdl/segment_intersection_top.sv
// top level of the segment intersection pipeline
//
//  channel | dir | carries
//  seg     | in  | segment pair a0, a1, b0, b1
//  res     | out | hit, hit_kind, hit_x, hit_y, hit_t
//
// one pair per cycle while res does not stall; the stages are five front stages
// (differences, products, cross sums, magnitudes, decision), one divider stage
// per quotient bit, a scale multiply and the output register
// reset clears only the valid bits; the whole pipeline holds while res stalls
`include "segment_intersection_top_macros.svh"

module segment_intersection_top #(
	parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH,
	parameter int T_FRAC_BITS = segi_pkg::T_FRAC_BITS
) (
	input logic        clk,
	input logic        arst_n,
	segi_in_if.sink    seg,
	segi_out_if.source res
);
	localparam int CW = COORD_WIDTH;
	localparam int F  = T_FRAC_BITS;
	localparam int D  = CW + 1;
	localparam int PW = 2 * D;
	localparam int NW = PW + 1;
	localparam int TW = F + 1;
	localparam int MW = TW + D;

	typedef struct packed {
		logic                 hit;
		logic [1:0]           kind;
		logic signed [CW-1:0] a0x;
		logic signed [CW-1:0] a0y;
		logic [D-1:0]         max;
		logic [D-1:0]         may;
		logic                 nax;
		logic                 nay;
	} side_t;

	localparam int SW = $bits(side_t);

	logic en;
	assign en        = !res.valid || res.ready;
	assign seg.ready = en;

	// stage 1: differences and endpoint matches
	logic signed [D-1:0]  dax_s1, day_s1, dbx_s1, dby_s1, wx_s1, wy_s1;
	logic signed [D-1:0]  e0x_s1, e0y_s1, e1x_s1, e1y_s1;
	logic signed [CW-1:0] a0x_s1, a0y_s1;
	logic                 eq00_s1, eq10_s1, eq01_s1, eq11_s1;
	logic [6:0]           vld_q;

	always_ff @(posedge clk) begin
		if (en) begin
			dax_s1  <= D'(seg.seg_a_end_x) - D'(seg.seg_a_start_x);
			day_s1  <= D'(seg.seg_a_end_y) - D'(seg.seg_a_start_y);
			dbx_s1  <= D'(seg.seg_b_end_x) - D'(seg.seg_b_start_x);
			dby_s1  <= D'(seg.seg_b_end_y) - D'(seg.seg_b_start_y);
			wx_s1   <= D'(seg.seg_a_start_x) - D'(seg.seg_b_start_x);
			wy_s1   <= D'(seg.seg_a_start_y) - D'(seg.seg_b_start_y);
			e0x_s1  <= D'(seg.seg_b_start_x) - D'(seg.seg_a_start_x);
			e0y_s1  <= D'(seg.seg_b_start_y) - D'(seg.seg_a_start_y);
			e1x_s1  <= D'(seg.seg_b_end_x) - D'(seg.seg_a_start_x);
			e1y_s1  <= D'(seg.seg_b_end_y) - D'(seg.seg_a_start_y);
			a0x_s1  <= seg.seg_a_start_x;
			a0y_s1  <= seg.seg_a_start_y;
			eq00_s1 <= seg.seg_b_start_x == seg.seg_a_start_x &&
				seg.seg_b_start_y == seg.seg_a_start_y;
			eq10_s1 <= seg.seg_b_end_x == seg.seg_a_start_x &&
				seg.seg_b_end_y == seg.seg_a_start_y;
			eq01_s1 <= seg.seg_b_start_x == seg.seg_a_end_x &&
				seg.seg_b_start_y == seg.seg_a_end_y;
			eq11_s1 <= seg.seg_b_end_x == seg.seg_a_end_x &&
				seg.seg_b_end_y == seg.seg_a_end_y;
		end
	end

	// stage 2: all products
	logic signed [PW-1:0] p_axwy_s2, p_aywx_s2, p_bxwy_s2, p_bywx_s2, p_axby_s2, p_aybx_s2;
	logic signed [PW-1:0] sq_ax_s2, sq_ay_s2, sq_e0x_s2, sq_e0y_s2, sq_e1x_s2, sq_e1y_s2;
	logic signed [D-1:0]  dax_s2, day_s2, e0x_s2, e0y_s2, e1x_s2, e1y_s2;
	logic signed [CW-1:0] a0x_s2, a0y_s2;
	logic                 eq00_s2, eq10_s2, eq01_s2, eq11_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p_axwy_s2 <= PW'(dax_s1) * PW'(wy_s1);
			p_aywx_s2 <= PW'(day_s1) * PW'(wx_s1);
			p_bxwy_s2 <= PW'(dbx_s1) * PW'(wy_s1);
			p_bywx_s2 <= PW'(dby_s1) * PW'(wx_s1);
			p_axby_s2 <= PW'(dax_s1) * PW'(dby_s1);
			p_aybx_s2 <= PW'(day_s1) * PW'(dbx_s1);
			sq_ax_s2  <= PW'(dax_s1) * PW'(dax_s1);
			sq_ay_s2  <= PW'(day_s1) * PW'(day_s1);
			sq_e0x_s2 <= PW'(e0x_s1) * PW'(e0x_s1);
			sq_e0y_s2 <= PW'(e0y_s1) * PW'(e0y_s1);
			sq_e1x_s2 <= PW'(e1x_s1) * PW'(e1x_s1);
			sq_e1y_s2 <= PW'(e1y_s1) * PW'(e1y_s1);
			dax_s2    <= dax_s1;
			day_s2    <= day_s1;
			e0x_s2    <= e0x_s1;
			e0y_s2    <= e0y_s1;
			e1x_s2    <= e1x_s1;
			e1y_s2    <= e1y_s1;
			a0x_s2    <= a0x_s1;
			a0y_s2    <= a0y_s1;
			eq00_s2   <= eq00_s1;
			eq10_s2   <= eq10_s1;
			eq01_s2   <= eq01_s1;
			eq11_s2   <= eq11_s1;
		end
	end

	// stage 3: cross products and squared lengths
	logic signed [NW-1:0] nom1_s3, nom2_s3, den_s3, la_s3, lb0_s3, lb1_s3;
	logic signed [D-1:0]  dax_s3, day_s3, e0x_s3, e0y_s3, e1x_s3, e1y_s3;
	logic signed [CW-1:0] a0x_s3, a0y_s3;
	logic                 eq00_s3, eq10_s3, eq01_s3, eq11_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			nom1_s3 <= NW'(p_bxwy_s2) - NW'(p_bywx_s2);
			nom2_s3 <= NW'(p_axwy_s2) - NW'(p_aywx_s2);
			den_s3  <= NW'(p_axby_s2) - NW'(p_aybx_s2);
			la_s3   <= NW'(sq_ax_s2) + NW'(sq_ay_s2);
			lb0_s3  <= NW'(sq_e0x_s2) + NW'(sq_e0y_s2);
			lb1_s3  <= NW'(sq_e1x_s2) + NW'(sq_e1y_s2);
			dax_s3  <= dax_s2;
			day_s3  <= day_s2;
			e0x_s3  <= e0x_s2;
			e0y_s3  <= e0y_s2;
			e1x_s3  <= e1x_s2;
			e1y_s3  <= e1y_s2;
			a0x_s3  <= a0x_s2;
			a0y_s3  <= a0y_s2;
			eq00_s3 <= eq00_s2;
			eq10_s3 <= eq10_s2;
			eq01_s3 <= eq01_s2;
			eq11_s3 <= eq11_s2;
		end
	end

	// stage 4: magnitudes, signs, zero tests, length compares
	logic [NW-1:0]        an1_s4, an2_s4, ad_s4;
	logic                 n1z_s4, n2z_s4, dz_s4, n1n_s4, n2n_s4, dn_s4;
	logic                 ge0_s4, ge1_s4, opp0_s4, opp1_s4, axnz_s4, aynz_s4;
	logic [D-1:0]         max_s4, may_s4, me0x_s4, me0y_s4, me1x_s4, me1y_s4;
	logic                 nax_s4, nay_s4;
	logic signed [CW-1:0] a0x_s4, a0y_s4;
	logic                 eq00_s4, eq10_s4, eq01_s4, eq11_s4;

	function automatic logic [D-1:0] mag_d(input logic signed [D-1:0] v);
		return v[D-1] ? D'(-v) : D'(v);
	endfunction

	function automatic logic [NW-1:0] mag_n(input logic signed [NW-1:0] v);
		return v[NW-1] ? NW'(-v) : NW'(v);
	endfunction

	// nonzero and of opposite sign
	function automatic logic opp(input logic signed [D-1:0] u, input logic signed [D-1:0] v);
		return u != '0 && v != '0 && (u[D-1] ^ v[D-1]);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			an1_s4  <= mag_n(nom1_s3);
			an2_s4  <= mag_n(nom2_s3);
			ad_s4   <= mag_n(den_s3);
			n1z_s4  <= nom1_s3 == '0;
			n2z_s4  <= nom2_s3 == '0;
			dz_s4   <= den_s3 == '0;
			n1n_s4  <= nom1_s3[NW-1];
			n2n_s4  <= nom2_s3[NW-1];
			dn_s4   <= den_s3[NW-1];
			ge0_s4  <= la_s3 >= lb0_s3;
			ge1_s4  <= la_s3 >= lb1_s3;
			opp0_s4 <= opp(dax_s3, e0x_s3) || opp(day_s3, e0y_s3);
			opp1_s4 <= opp(dax_s3, e1x_s3) || opp(day_s3, e1y_s3);
			axnz_s4 <= dax_s3 != '0;
			aynz_s4 <= day_s3 != '0;
			max_s4  <= mag_d(dax_s3);
			may_s4  <= mag_d(day_s3);
			me0x_s4 <= mag_d(e0x_s3);
			me0y_s4 <= mag_d(e0y_s3);
			me1x_s4 <= mag_d(e1x_s3);
			me1y_s4 <= mag_d(e1y_s3);
			nax_s4  <= dax_s3[D-1];
			nay_s4  <= day_s3[D-1];
			a0x_s4  <= a0x_s3;
			a0y_s4  <= a0y_s3;
			eq00_s4 <= eq00_s3;
			eq10_s4 <= eq10_s3;
			eq01_s4 <= eq01_s3;
			eq11_s4 <= eq11_s3;
		end
	end

	// stage 5: decide the case and pick divider operands
	side_t         side_d, side_s5;
	logic [NW-1:0] num_d, den_d, num_s5, den_s5;
	logic          ins0, ins1, fail1, fail2;
	logic [D-1:0]  cnum0, cnum1, cden;

	always_comb begin
		ins0  = !eq00_s4 && !eq01_s4 && !opp0_s4 && ge0_s4 && (axnz_s4 || aynz_s4);
		ins1  = !eq10_s4 && !eq11_s4 && !opp1_s4 && ge1_s4 && (axnz_s4 || aynz_s4);
		cnum0 = axnz_s4 ? me0x_s4 : me0y_s4;
		cnum1 = axnz_s4 ? me1x_s4 : me1y_s4;
		cden  = axnz_s4 ? max_s4 : may_s4;
		fail1 = n1z_s4 || (n1n_s4 != dn_s4) || (an1_s4 >= ad_s4);
		fail2 = !n2z_s4 && ((n2n_s4 != dn_s4) || (an2_s4 > ad_s4));

		side_d.hit  = 1'b0;
		side_d.kind = segi_pkg::KIND_CROSS;
		side_d.a0x  = a0x_s4;
		side_d.a0y  = a0y_s4;
		side_d.max  = max_s4;
		side_d.may  = may_s4;
		side_d.nax  = nax_s4;
		side_d.nay  = nay_s4;
		num_d       = NW'(cnum0);
		den_d       = NW'(cden);

		if (dz_s4) begin
			if (n1z_s4 && n2z_s4) begin
				if (eq00_s4) begin
					side_d.hit  = 1'b1;
					side_d.kind = segi_pkg::KIND_ORIGIN;
				end else if (ins0) begin
					side_d.hit  = 1'b1;
					side_d.kind = segi_pkg::KIND_INSIDE;
				end else if (eq10_s4) begin
					side_d.hit  = 1'b1;
					side_d.kind = segi_pkg::KIND_ORIGIN;
				end else if (ins1) begin
					side_d.hit  = 1'b1;
					side_d.kind = segi_pkg::KIND_INSIDE;
					num_d       = NW'(cnum1);
				end
			end
		end else if (!fail1 && !fail2) begin
			side_d.hit = 1'b1;
			if (eq00_s4 || eq10_s4) begin
				side_d.kind = segi_pkg::KIND_ORIGIN;
			end else begin
				side_d.kind = segi_pkg::KIND_CROSS;
				num_d       = an1_s4;
				den_d       = ad_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_d;
			num_s5  <= num_d;
			den_s5  <= den_d;
		end
	end

	// divider stages
	logic          dvld;
	logic [F:0]    quo;
	logic [SW-1:0] dside_bits;
	side_t         dside;

	segi_div #(
		.NW(NW),
		.FB(F),
		.SW(SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_q[4]),
		.num      (num_s5),
		.den      (den_s5),
		.side_in  (SW'(side_s5)),
		.out_valid(dvld),
		.quo      (quo),
		.side_out (dside_bits)
	);

	assign dside = side_t'(dside_bits);

	// scale stage: t times |d| per axis
	logic [MW-1:0] px_sm, py_sm;
	logic [F:0]    t_sm;
	side_t         side_sm;

	always_ff @(posedge clk) begin
		if (en) begin
			px_sm   <= MW'(quo) * MW'(dside.max);
			py_sm   <= MW'(quo) * MW'(dside.may);
			t_sm    <= quo;
			side_sm <= dside;
		end
	end

	// output stage: truncate offset toward zero and add a0
	logic [CW-1:0] offx, offy;
	always_comb begin
		offx = CW'(px_sm >> F);
		offy = CW'(py_sm >> F);
		if (side_sm.nax) offx = -offx;
		if (side_sm.nay) offy = -offy;
	end

	logic                 hit_q;
	logic [1:0]           kind_q;
	logic signed [CW-1:0] x_q, y_q;
	logic [F:0]           t_q;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= side_sm.hit;
			kind_q <= side_sm.hit ? side_sm.kind : segi_pkg::KIND_CROSS;
			x_q    <= '0;
			y_q    <= '0;
			t_q    <= '0;
			if (side_sm.hit) begin
				case (side_sm.kind)
					segi_pkg::KIND_ORIGIN: begin
						x_q <= side_sm.a0x;
						y_q <= side_sm.a0y;
					end
					segi_pkg::KIND_CROSS, segi_pkg::KIND_INSIDE: begin
						x_q <= side_sm.a0x + $signed(offx);
						y_q <= side_sm.a0y + $signed(offy);
						t_q <= t_sm;
					end
					default: begin
						x_q <= '0;
						y_q <= '0;
					end
				endcase
			end
		end
	end

	// valid bits: s1..s5 in [4:0], scale in [5], output in [6]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q[4:0] <= {vld_q[3:0], seg.valid};
			vld_q[5]   <= dvld;
			vld_q[6]   <= vld_q[5];
		end
	end

	assign res.valid    = vld_q[6];
	assign res.hit      = hit_q;
	assign res.hit_kind = kind_q;
	assign res.hit_x    = x_q;
	assign res.hit_y    = y_q;
	assign res.hit_t    = t_q;

	`SEGI_CHECK(a_nohit_zero, res.valid && !res.hit, res.hit_kind == segi_pkg::KIND_CROSS && res.hit_x == '0 && res.hit_y == '0 && res.hit_t == '0, "no-hit result not all zero")
	`SEGI_CHECK(a_origin_t, res.valid && res.hit && res.hit_kind == segi_pkg::KIND_ORIGIN, res.hit_t == '0, "origin hit with nonzero t")
	`SEGI_CHECK(a_cross_t, res.valid && res.hit && res.hit_kind == segi_pkg::KIND_CROSS, !res.hit_t[F], "crossing t not below one")
	`SEGI_CHECK_NEXT(a_hold, res.valid && !res.ready, res.valid && $stable(res.hit_x) && $stable(res.hit_t), "stalled result changed")
endmodule

>>> hdl/segi_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module segi_div #(
	parameter int NW = 67,
	parameter int FB = segi_pkg::T_FRAC_BITS,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [FB:0]   quo,
	output logic [SW-1:0] side_out
);
	localparam int RW = NW + 1;

	logic [RW-1:0] rem_s  [0:FB-1];
	logic [NW-1:0] den_s  [0:FB-1];
	logic [FB:0]   quo_s  [0:FB];
	logic [SW-1:0] side_s [0:FB];
	logic [FB:0]   vld_s;

	// first step takes the integer bit
	always_ff @(posedge clk) begin
		if (en) begin
			if (num >= den) begin
				rem_s[0] <= RW'(num - den);
				quo_s[0] <= (FB+1)'(1);
			end else begin
				rem_s[0] <= RW'(num);
				quo_s[0] <= '0;
			end
			den_s[0]  <= den;
			side_s[0] <= side_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[FB-1:0], in_valid};
		end
	end

	for (genvar k = 1; k <= FB; k++) begin : g_step
		logic [RW-1:0] shifted;
		logic          ge;
		// remainder stays below den, so the shift fits
		assign shifted = {rem_s[k-1][NW-1:0], 1'b0};
		assign ge      = shifted >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k]  <= {quo_s[k-1][FB-1:0], ge};
				side_s[k] <= side_s[k-1];
			end
		end
		// the last step needs no remainder
		if (k < FB) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? shifted - {1'b0, den_s[k-1]} : shifted;
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign out_valid = vld_s[FB];
	assign quo       = quo_s[FB];
	assign side_out  = side_s[FB];
endmodule
